@@ rtl/rsort_pkg.sv @@
// Shared types and command bundle for the two-key record sorter.
`timescale 1ns / 1ps
package rsort_pkg;

  // One input transaction: a record plus the end-of-set marker.
  typedef struct packed {
    logic [15:0] type_key;
    logic [15:0] record_key;
    logic [15:0] color_code;
    logic [9:0]  engine_size;
    logic        slot_empty;
    logic        last_in;
  } item_t;

  // One sorted output transaction.
  typedef struct packed {
    logic [15:0] out_type_key;
    logic [15:0] out_record_key;
    logic [15:0] out_color_code;
    logic [9:0]  out_engine_size;
    logic        out_slot_empty;
    logic        overflow;
    logic        last_out;
  } result_t;

  // A record as held in the store.
  typedef struct packed {
    logic [15:0] type_key;
    logic [15:0] record_key;
    logic [15:0] color_code;
    logic [9:0]  engine_size;
    logic        slot_empty;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_in;       // write the incoming record
    logic wr_hold;     // write the holding register back
    logic load_hold;   // load the holding register from read data
    logic cmp;         // compare read data against holder, swap if smaller
    logic emit;        // the read address this cycle selects an output record
    logic emit_last;   // that output record is the final one
    logic set_ovf;     // a record was dropped
    logic clr_ovf;     // set finished
  } cmd_t;

endpackage

@@ rtl/rsort_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsort_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rsort_dp.sv @@
// Datapath: record store, holding register, key compare and result register.
`timescale 1ns / 1ps
module rsort_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rsort_pkg::cmd_t            cmd,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  input  rsort_pkg::item_t           item,
  output logic                       done,
  output rsort_pkg::result_t         result
);

  rsort_pkg::rec_t in_rec;
  rsort_pkg::rec_t rd_rec;
  rsort_pkg::rec_t holder;
  rsort_pkg::rec_t wr_rec;
  logic            swap;
  logic            ram_we;
  logic            overflow_seen;
  logic            emit_pend;
  logic            last_pend;

  assign in_rec = '{type_key:    item.type_key,
                    record_key:  item.record_key,
                    color_code:  item.color_code,
                    engine_size: item.engine_size,
                    slot_empty:  item.slot_empty};

  // The holder carries the record at the current outer position; a smaller
  // record read from a later position trades places with it.
  assign swap   = {holder.type_key, holder.record_key} >
                  {rd_rec.type_key, rd_rec.record_key};
  assign ram_we = cmd.wr_in | cmd.wr_hold | (cmd.cmp & swap);
  assign wr_rec = cmd.wr_in ? in_rec : holder;

  rsort_ram #(
    .WIDTH (rsort_pkg::RecW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wr_rec),
    .raddr (raddr),
    .rdata (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_hold || (cmd.cmp && swap)) begin
      holder <= rd_rec;
    end
    if (emit_pend) begin
      result <= '{out_type_key:    rd_rec.type_key,
                  out_record_key:  rd_rec.record_key,
                  out_color_code:  rd_rec.color_code,
                  out_engine_size: rd_rec.engine_size,
                  out_slot_empty:  rd_rec.slot_empty,
                  overflow:        overflow_seen,
                  last_out:        last_pend};
    end
    last_pend <= cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
      emit_pend     <= 1'b0;
      done          <= 1'b0;
    end else begin
      emit_pend <= cmd.emit;
      done      <= emit_pend;
      if (cmd.clr_ovf) begin
        overflow_seen <= 1'b0;
      end else if (cmd.set_ovf) begin
        overflow_seen <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/rsort_ctrl.sv @@
// Controller: load sequencing, exchange-sort passes and output readout.
`timescale 1ns / 1ps
module rsort_ctrl #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     last_in,
  output logic                     busy,
  output rsort_pkg::cmd_t          cmd,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic [$clog2(DEPTH)-1:0] raddr
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ_I,
    S_HOLD,
    S_CMP,
    S_WB,
    S_EMIT,
    S_DRAIN
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic          has_room;
  logic          j_last;
  logic          i_last;
  logic          k_last;

  assign has_room = count < CW'(DEPTH);
  assign j_last   = (CW'(j) + CW'(1)) == count;
  assign i_last   = (CW'(i) + CW'(2)) == count;
  assign k_last   = (CW'(k) + CW'(1)) == count;
  assign busy     = (state != S_LOAD);

  always_comb begin
    cmd   = '0;
    waddr = '0;
    raddr = '0;
    unique case (state)
      S_LOAD: begin
        waddr       = count[AW-1:0];
        cmd.wr_in   = start & has_room;
        cmd.set_ovf = start & ~has_room;
      end
      S_READ_I: begin
        raddr = i;
      end
      S_HOLD: begin
        raddr         = j;
        cmd.load_hold = 1'b1;
      end
      S_CMP: begin
        waddr   = j;
        raddr   = j + AW'(1);
        cmd.cmp = 1'b1;
      end
      S_WB: begin
        waddr       = i;
        cmd.wr_hold = 1'b1;
      end
      S_EMIT: begin
        raddr         = k;
        cmd.emit      = 1'b1;
        cmd.emit_last = k_last;
      end
      S_DRAIN: begin
        cmd.clr_ovf = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (start) begin
            if (has_room) begin
              count <= count + CW'(1);
            end
            if (last_in) begin
              i <= '0;
              k <= '0;
              // A set of one record needs no sorting.
              if (count == '0) begin
                state <= S_EMIT;
              end else begin
                state <= S_READ_I;
              end
            end
          end
        end
        S_READ_I: begin
          j     <= i + AW'(1);
          state <= S_HOLD;
        end
        S_HOLD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (j_last) begin
            state <= S_WB;
          end else begin
            j <= j + AW'(1);
          end
        end
        S_WB: begin
          if (i_last) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            i     <= i + AW'(1);
            state <= S_READ_I;
          end
        end
        S_EMIT: begin
          if (k_last) begin
            state <= S_DRAIN;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_DRAIN: begin
          count <= '0;
          state <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

@@ rtl/record_sort_two_key_core.sv @@
// Top level of the two-key record sorter: controller plus datapath.
//
// Records are loaded one per transaction while busy is low.
// The transaction with last_in set closes the set (up to DEPTH records are
// kept; further ones are dropped and flagged as overflow). The block then
// runs an exchange sort on its single-port-read record RAM: for n records,
// each outer position i reads record i into the holding register, compares
// the holder with each later record in turn, trading places with a smaller
// one, and writes the holder back to position i. The n sorted records then
// appear on result, one per cycle on consecutive cycles, each marked by done
// for one cycle; the receiver cannot stall them. busy rises after the
// closing transaction and falls in the cycle that shows the final result.
`timescale 1ns / 1ps
module record_sort_two_key_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rsort_pkg::item_t    item,
  output logic                done,
  output rsort_pkg::result_t  result
);

  rsort_pkg::cmd_t            cmd;
  logic [$clog2(DEPTH)-1:0]   waddr;
  logic [$clog2(DEPTH)-1:0]   raddr;

  rsort_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (item.last_in),
    .busy    (busy),
    .cmd     (cmd),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  rsort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .waddr  (waddr),
    .raddr  (raddr),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // Results only come out of a set that is being processed.
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a set in progress");

  // Sorted records leave on back-to-back cycles until the final one.
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last_out) |=> done)
    else $error("gap inside the result burst");

  // The final result ends the burst and frees the block for the next set.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (done && result.last_out) |-> !busy)
    else $error("block still busy on the final result");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (done && result.last_out) |=> !done)
    else $error("result strobe after the final result");

endmodule
